[hw/rtl/bcd_pkg.sv]
`default_nettype none

package bcd_pkg;

   localparam int MAX_WIDTH_DEFAULT     = 8192;
   localparam int FRACTION_BITS_DEFAULT = 12;
   localparam int MAX_HEIGHT            = 8192;

   localparam int SAMPLE_W = 16;
   localparam int GEOM_W   = 14;
   localparam int ROW_W    = 13;
   localparam int COLOUR_W = 2;
   localparam int VAL_W    = SAMPLE_W + 1;
   localparam int SUM_W    = 20;
   localparam int DEN_W    = 20;
   localparam int COUNT_W  = 4;
   localparam int TAP_W    = 4;
   localparam int CSR_AW   = 5;
   localparam int CSR_DW   = 32;

   localparam logic [TAP_W-1:0] TAP_CENTRE = 4'd4;
   localparam logic [TAP_W-1:0] TAP_LAST   = 4'd9;

   localparam logic [COLOUR_W-1:0] COLOUR_RED    = 2'd0;
   localparam logic [COLOUR_W-1:0] COLOUR_GREEN  = 2'd1;
   localparam logic [COLOUR_W-1:0] COLOUR_BLUE   = 2'd2;
   localparam logic [COLOUR_W-1:0] COLOUR_UNUSED = 2'd3;

   typedef enum logic [2:0] {
      REG_IMAGE_WIDTH  = 3'd0,
      REG_IMAGE_HEIGHT = 3'd1,
      REG_BLACK_LEVEL  = 3'd2,
      REG_WHITE_LEVEL  = 3'd3,
      REG_CFA_COLOUR_0 = 3'd4,
      REG_CFA_COLOUR_1 = 3'd5,
      REG_CFA_COLOUR_2 = 3'd6,
      REG_CFA_COLOUR_3 = 3'd7
   } reg_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_READ,
      ST_DIVIDE,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic                    start;
      logic signed [SUM_W-1:0] num;
      logic [DEN_W-1:0]        den;
   } div_req_type;

   function automatic logic [1:0] tap_row(input logic [TAP_W-1:0] k);
      logic [1:0] r;
      case (k) inside
         [4'd0:4'd2]: r = 2'd0;
         [4'd3:4'd5]: r = 2'd1;
         default:     r = 2'd2;
      endcase
      return r;
   endfunction

   function automatic logic [1:0] tap_col(input logic [TAP_W-1:0] k);
      logic [1:0] c;
      case (k) inside
         4'd0, 4'd3, 4'd6: c = 2'd0;
         4'd1, 4'd4, 4'd7: c = 2'd1;
         default:          c = 2'd2;
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

[hw/rtl/bcd_if.sv]
`default_nettype none

interface bcd_req_if;
   logic                          valid;
   logic                          ready;
   logic [bcd_pkg::SAMPLE_W-1:0]  raw_sample;
   logic                          sample_present;

   modport source(output valid, raw_sample, sample_present, input ready);
   modport sink(input valid, raw_sample, sample_present, output ready);
endinterface

interface bcd_rsp_if #(
   parameter int FRACTION_BITS = bcd_pkg::FRACTION_BITS_DEFAULT
);
   logic                   valid;
   logic                   ready;
   logic [FRACTION_BITS:0] red;
   logic [FRACTION_BITS:0] green;
   logic [FRACTION_BITS:0] blue;
   logic                   frame_end;

   modport source(output valid, red, green, blue, frame_end, input ready);
   modport sink(input valid, red, green, blue, frame_end, output ready);
endinterface

`default_nettype wire

[hw/rtl/bcd_line_store.sv]
`default_nettype none

module bcd_line_store #(
   parameter int MAX_WIDTH = bcd_pkg::MAX_WIDTH_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          wr_en,
   input  wire logic [$clog2(MAX_WIDTH)+1:0]  wr_addr,
   input  wire logic [bcd_pkg::SAMPLE_W-1:0]  wr_data,
   input  wire logic                          rd_en,
   input  wire logic [$clog2(MAX_WIDTH)+1:0]  rd_addr,
   output logic [bcd_pkg::SAMPLE_W-1:0]       rd_data
);

   localparam int AW    = $clog2(MAX_WIDTH) + 2;
   localparam int DEPTH = 1 << AW;

   logic [bcd_pkg::SAMPLE_W-1:0] mem [DEPTH];
   logic [bcd_pkg::SAMPLE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[hw/rtl/bcd_divider.sv]
`default_nettype none

module bcd_divider #(
   parameter int FRACTION_BITS = bcd_pkg::FRACTION_BITS_DEFAULT
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire bcd_pkg::div_req_type req,
   output logic                      done,
   output logic [FRACTION_BITS:0]    quotient
);

   localparam int QW  = FRACTION_BITS + 1;
   localparam int NW  = bcd_pkg::DEN_W + FRACTION_BITS + 2;
   localparam int SW  = NW - 1;
   localparam int CNW = $clog2(QW + 1);
   localparam logic [QW-1:0] ONE = QW'(1) << FRACTION_BITS;

   logic            busy_ff, busy_in;
   logic            done_ff, done_in;
   logic [CNW-1:0]  cnt_ff, cnt_in;
   logic [NW-1:0]   rem_ff, rem_in;
   logic [SW-1:0]   dvs_ff, dvs_in;
   logic [QW-1:0]   q_ff, q_in;

   logic [bcd_pkg::DEN_W:0] num_mag;
   logic [bcd_pkg::DEN_W:0] den_ext;
   logic [NW:0]             trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      q_in    = q_ff;
      num_mag = (bcd_pkg::DEN_W + 1)'($unsigned(req.num));
      den_ext = {1'b0, req.den};
      trial   = {1'b0, rem_ff} - {2'b00, dvs_ff};
      if (busy_ff) begin
         if (!trial[NW]) begin
            rem_in = trial[NW-1:0];
         end
         q_in   = {q_ff[QW-2:0], ~trial[NW]};
         dvs_in = dvs_ff >> 1;
         cnt_in = cnt_ff - CNW'(1);
         if (cnt_ff == CNW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (req.start) begin
         if (req.num <= 0 || req.den == '0) begin
            q_in    = '0;
            done_in = 1'b1;
         end else if (num_mag >= den_ext) begin
            q_in    = ONE;
            done_in = 1'b1;
         end else begin
            rem_in  = (NW'(num_mag) << (FRACTION_BITS + 1)) + NW'(req.den);
            dvs_in  = SW'({req.den, 1'b0}) << FRACTION_BITS;
            q_in    = '0;
            cnt_in  = CNW'(QW);
            busy_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      q_ff   <= q_in;
   end

   assign done     = done_ff;
   assign quotient = q_ff;

endmodule

`default_nettype wire

[hw/rtl/bilinear_cfa_demosaic_top.sv]
// An accepted input transaction goes through ST_CHECK; one that completes a pixel then runs ST_READ,
// ST_DIVIDE and ST_EMIT before its result is offered, while one that completes none returns to ST_IDLE.
// Throughput: one transaction at a time; the 3x3 window is fetched one sample per
// cycle from the single line store read port and one shared divider forms the three colours.
// Reset is synchronous: counters, control and configuration registers return to their defaults,
// the datapath registers and the line store contents are left as they are.
`default_nettype none

module bilinear_cfa_demosaic_top #(
   parameter int MAX_WIDTH     = bcd_pkg::MAX_WIDTH_DEFAULT,
   parameter int FRACTION_BITS = bcd_pkg::FRACTION_BITS_DEFAULT
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   bcd_req_if.sink                          req_chan,
   bcd_rsp_if.source                        rsp_chan,
   input  wire logic                        csr_psel,
   input  wire logic                        csr_penable,
   input  wire logic                        csr_pwrite,
   input  wire logic [bcd_pkg::CSR_AW-1:0]  csr_paddr,
   input  wire logic [bcd_pkg::CSR_DW-1:0]  csr_pwdata,
   output logic [bcd_pkg::CSR_DW-1:0]       csr_prdata,
   output logic                             csr_pready
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int EW = CW + 1;
   localparam int PW = EW + 1;
   localparam int AW = CW + 2;
   localparam int QW = FRACTION_BITS + 1;
   localparam int GW = bcd_pkg::GEOM_W;
   localparam int RW = bcd_pkg::ROW_W;
   localparam int SW = bcd_pkg::SAMPLE_W;
   localparam int VW = bcd_pkg::VAL_W;
   localparam int UW = bcd_pkg::SUM_W;
   localparam int NW = bcd_pkg::COUNT_W;
   localparam int DW = bcd_pkg::DEN_W;
   localparam int KW = bcd_pkg::TAP_W;
   localparam int LW = bcd_pkg::COLOUR_W;

   logic [GW-1:0] width_ff, height_ff;
   logic [SW-1:0] black_ff, white_ff;
   logic [LW-1:0] cfa_ff [4];

   bcd_pkg::state_type state_ff, state_in;
   logic [CW-1:0]      icol_ff, icol_in, ocol_ff, ocol_in;
   logic [RW-1:0]      irow_ff, irow_in, orow_ff, orow_in;
   logic [1:0]         islot_ff, islot_in, oslot_ff, oslot_in;
   logic [PW-1:0]      pend_ff, pend_in;
   logic [KW-1:0]      k_ff, k_in;
   logic [1:0]         j_ff, j_in;
   logic               busy_ff, busy_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic [SW-1:0]          d_ff, d_in;
   logic signed [VW-1:0]   centre_ff, centre_in;
   logic signed [UW-1:0]   sum_ff [3];
   logic signed [UW-1:0]   sum_in [3];
   logic [NW-1:0]          cnt_ff [3];
   logic [NW-1:0]          cnt_in [3];
   logic [QW-1:0]          res_ff [3];
   logic [QW-1:0]          res_in [3];
   logic [QW-1:0]          red_ff, green_ff, blue_ff;
   logic                   fend_ff;
   logic                   load_rsp;

   logic [EW-1:0]   eff_w;
   logic [GW-1:0]   eff_h;
   logic [CW-1:0]   ic_c, oc_c;
   logic [RW-1:0]   ir_c, or_c;
   logic            last_row, last_col;
   logic [PW-1:0]   offset;
   logic [1:0]      own_cls;
   logic [LW-1:0]   own_code;
   logic [1:0]      rd_dy, rd_dx, ac_dy, ac_dx;
   logic [KW-1:0]   k_prev;
   logic            inbound;
   logic [LW-1:0]   nb_code;
   logic signed [VW-1:0] nb_val;

   logic            mem_we, mem_re;
   logic [AW-1:0]   mem_waddr, mem_raddr;
   logic [SW-1:0]   mem_rdata;

   bcd_pkg::div_req_type div_req;
   logic                 div_done;
   logic [QW-1:0]        div_q;

   logic                   csr_write;
   bcd_pkg::reg_index_type csr_index;

   // Configuration port.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite;
   assign csr_index  = bcd_pkg::reg_index_type'(csr_paddr[4:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= GW'(bcd_pkg::MAX_WIDTH_DEFAULT);
         height_ff <= GW'(bcd_pkg::MAX_HEIGHT);
         black_ff  <= '0;
         white_ff  <= '1;
         cfa_ff[0] <= bcd_pkg::COLOUR_RED;
         cfa_ff[1] <= bcd_pkg::COLOUR_GREEN;
         cfa_ff[2] <= bcd_pkg::COLOUR_GREEN;
         cfa_ff[3] <= bcd_pkg::COLOUR_BLUE;
      end else if (csr_write) begin
         unique case (csr_index)
            bcd_pkg::REG_IMAGE_WIDTH:  width_ff  <= csr_pwdata[GW-1:0];
            bcd_pkg::REG_IMAGE_HEIGHT: height_ff <= csr_pwdata[GW-1:0];
            bcd_pkg::REG_BLACK_LEVEL:  black_ff  <= csr_pwdata[SW-1:0];
            bcd_pkg::REG_WHITE_LEVEL:  white_ff  <= csr_pwdata[SW-1:0];
            bcd_pkg::REG_CFA_COLOUR_0: cfa_ff[0] <= csr_pwdata[LW-1:0];
            bcd_pkg::REG_CFA_COLOUR_1: cfa_ff[1] <= csr_pwdata[LW-1:0];
            bcd_pkg::REG_CFA_COLOUR_2: cfa_ff[2] <= csr_pwdata[LW-1:0];
            bcd_pkg::REG_CFA_COLOUR_3: cfa_ff[3] <= csr_pwdata[LW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         bcd_pkg::REG_IMAGE_WIDTH:  csr_prdata = 32'(width_ff);
         bcd_pkg::REG_IMAGE_HEIGHT: csr_prdata = 32'(height_ff);
         bcd_pkg::REG_BLACK_LEVEL:  csr_prdata = 32'(black_ff);
         bcd_pkg::REG_WHITE_LEVEL:  csr_prdata = 32'(white_ff);
         bcd_pkg::REG_CFA_COLOUR_0: csr_prdata = 32'(cfa_ff[0]);
         bcd_pkg::REG_CFA_COLOUR_1: csr_prdata = 32'(cfa_ff[1]);
         bcd_pkg::REG_CFA_COLOUR_2: csr_prdata = 32'(cfa_ff[2]);
         bcd_pkg::REG_CFA_COLOUR_3: csr_prdata = 32'(cfa_ff[3]);
         default:                   csr_prdata = '0;
      endcase
   end

   // Effective geometry and counter clamps.
   always_comb begin
      if (width_ff == '0) begin
         eff_w = EW'(1);
      end else if (int'(width_ff) > MAX_WIDTH) begin
         eff_w = EW'(MAX_WIDTH);
      end else begin
         eff_w = EW'(width_ff);
      end
      if (height_ff == '0) begin
         eff_h = GW'(1);
      end else if (int'(height_ff) > bcd_pkg::MAX_HEIGHT) begin
         eff_h = GW'(bcd_pkg::MAX_HEIGHT);
      end else begin
         eff_h = height_ff;
      end
      ic_c = ({1'b0, icol_ff} >= eff_w) ? CW'(eff_w - EW'(1)) : icol_ff;
      oc_c = ({1'b0, ocol_ff} >= eff_w) ? CW'(eff_w - EW'(1)) : ocol_ff;
      ir_c = ({1'b0, irow_ff} >= eff_h) ? RW'(eff_h - GW'(1)) : irow_ff;
      or_c = ({1'b0, orow_ff} >= eff_h) ? RW'(eff_h - GW'(1)) : orow_ff;
      last_row = ({1'b0, orow_ff} + GW'(1)) >= eff_h;
      last_col = ({1'b0, ocol_ff} + EW'(1)) >= eff_w;
      offset   = (last_row ? PW'(0) : PW'(eff_w)) + (last_col ? PW'(0) : PW'(1));
      own_code = cfa_ff[{orow_ff[0], ocol_ff[0]}];
      if (own_code == bcd_pkg::COLOUR_RED) begin
         own_cls = 2'd0;
      end else if (own_code == bcd_pkg::COLOUR_BLUE) begin
         own_cls = 2'd2;
      end else begin
         own_cls = 2'd1;
      end
   end

   // Window taps.
   always_comb begin
      rd_dy   = bcd_pkg::tap_row(k_ff);
      rd_dx   = bcd_pkg::tap_col(k_ff);
      k_prev  = k_ff - KW'(1);
      ac_dy   = bcd_pkg::tap_row(k_prev);
      ac_dx   = bcd_pkg::tap_col(k_prev);
      inbound = 1'b1;
      if (ac_dy == 2'd0 && orow_ff == '0) begin
         inbound = 1'b0;
      end
      if (ac_dy == 2'd2 && last_row) begin
         inbound = 1'b0;
      end
      if (ac_dx == 2'd0 && ocol_ff == '0) begin
         inbound = 1'b0;
      end
      if (ac_dx == 2'd2 && last_col) begin
         inbound = 1'b0;
      end
      nb_code = cfa_ff[{orow_ff[0] ^ (ac_dy != 2'd1), ocol_ff[0] ^ (ac_dx != 2'd1)}];
      nb_val  = $signed({1'b0, mem_rdata}) - $signed({1'b0, black_ff});
   end

   assign mem_raddr = {oslot_ff + rd_dy + 2'b11, ocol_ff + CW'(rd_dx) - CW'(1)};

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      icol_in      = icol_ff;
      irow_in      = irow_ff;
      islot_in     = islot_ff;
      ocol_in      = ocol_ff;
      orow_in      = orow_ff;
      oslot_in     = oslot_ff;
      pend_in      = pend_ff;
      k_in         = k_ff;
      j_in         = j_ff;
      busy_in      = busy_ff;
      d_in         = d_ff;
      centre_in    = centre_ff;
      sum_in       = sum_ff;
      cnt_in       = cnt_ff;
      res_in       = res_ff;
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      mem_waddr    = {islot_ff, ic_c};
      load_rsp     = 1'b0;
      div_req      = '0;
      rsp_valid_in = rsp_valid_ff & ~rsp_chan.ready;

      if (j_ff == own_cls) begin
         div_req.num = UW'(centre_ff);
         div_req.den = DW'(d_ff);
      end else begin
         div_req.num = sum_ff[j_ff];
         div_req.den = DW'(cnt_ff[j_ff]) * DW'(d_ff);
      end

      unique case (state_ff)
         bcd_pkg::ST_IDLE: begin
            if (req_chan.valid) begin
               ocol_in = oc_c;
               orow_in = or_c;
               icol_in = ic_c;
               irow_in = ir_c;
               if (req_chan.sample_present) begin
                  mem_we  = 1'b1;
                  pend_in = pend_ff + PW'(1);
                  if (({1'b0, ic_c} + EW'(1)) >= eff_w) begin
                     icol_in  = '0;
                     islot_in = islot_ff + 2'd1;
                     irow_in  = (({1'b0, ir_c} + GW'(1)) >= eff_h) ? '0 : ir_c + RW'(1);
                  end else begin
                     icol_in = ic_c + CW'(1);
                  end
               end
               state_in = bcd_pkg::ST_CHECK;
            end
         end
         bcd_pkg::ST_CHECK: begin
            d_in = (white_ff > black_ff) ? white_ff - black_ff : SW'(1);
            if (pend_ff > offset) begin
               k_in     = '0;
               sum_in   = '{default: '0};
               cnt_in   = '{default: '0};
               state_in = bcd_pkg::ST_READ;
            end else begin
               state_in = bcd_pkg::ST_IDLE;
            end
         end
         bcd_pkg::ST_READ: begin
            if (k_ff != bcd_pkg::TAP_LAST) begin
               mem_re = 1'b1;
            end
            if (k_ff != '0) begin
               if (k_prev == bcd_pkg::TAP_CENTRE) begin
                  centre_in = nb_val;
               end else if (inbound && nb_code != bcd_pkg::COLOUR_UNUSED) begin
                  sum_in[nb_code] = sum_ff[nb_code] + UW'(nb_val);
                  cnt_in[nb_code] = cnt_ff[nb_code] + NW'(1);
               end
            end
            k_in = k_ff + KW'(1);
            if (k_ff == bcd_pkg::TAP_LAST) begin
               j_in     = '0;
               busy_in  = 1'b0;
               state_in = bcd_pkg::ST_DIVIDE;
            end
         end
         bcd_pkg::ST_DIVIDE: begin
            if (div_done) begin
               res_in[j_ff] = div_q;
               busy_in      = 1'b0;
               j_in         = j_ff + 2'd1;
               if (j_ff == 2'd2) begin
                  j_in     = '0;
                  state_in = bcd_pkg::ST_EMIT;
               end
            end else if (!busy_ff) begin
               div_req.start = 1'b1;
               busy_in       = 1'b1;
            end
         end
         bcd_pkg::ST_EMIT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               load_rsp     = 1'b1;
               rsp_valid_in = 1'b1;
               pend_in      = pend_ff - PW'(1);
               if (last_col) begin
                  ocol_in  = '0;
                  oslot_in = oslot_ff + 2'd1;
                  orow_in  = last_row ? '0 : orow_ff + RW'(1);
               end else begin
                  ocol_in = ocol_ff + CW'(1);
               end
               state_in = bcd_pkg::ST_IDLE;
            end
         end
         default: state_in = bcd_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bcd_pkg::ST_IDLE;
         icol_ff      <= '0;
         irow_ff      <= '0;
         islot_ff     <= '0;
         ocol_ff      <= '0;
         orow_ff      <= '0;
         oslot_ff     <= '0;
         pend_ff      <= '0;
         k_ff         <= '0;
         j_ff         <= '0;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         icol_ff      <= icol_in;
         irow_ff      <= irow_in;
         islot_ff     <= islot_in;
         ocol_ff      <= ocol_in;
         orow_ff      <= orow_in;
         oslot_ff     <= oslot_in;
         pend_ff      <= pend_in;
         k_ff         <= k_in;
         j_ff         <= j_in;
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      d_ff      <= d_in;
      centre_ff <= centre_in;
      sum_ff    <= sum_in;
      cnt_ff    <= cnt_in;
      res_ff    <= res_in;
      if (load_rsp) begin
         red_ff   <= res_ff[0];
         green_ff <= res_ff[1];
         blue_ff  <= res_ff[2];
         fend_ff  <= last_row & last_col;
      end
   end

   assign req_chan.ready     = (state_ff == bcd_pkg::ST_IDLE);
   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.red       = red_ff;
   assign rsp_chan.green     = green_ff;
   assign rsp_chan.blue      = blue_ff;
   assign rsp_chan.frame_end = fend_ff;

   bcd_line_store #(
      .MAX_WIDTH(MAX_WIDTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (req_chan.raw_sample),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   bcd_divider #(
      .FRACTION_BITS(FRACTION_BITS)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .req      (div_req),
      .done     (div_done),
      .quotient (div_q)
   );

endmodule

`default_nettype wire
